// ===== design/smpt_pkg.sv =====
`default_nettype none

package smpt_pkg;

    localparam int TRAVEL_W   = 16;
    localparam int TIME_W     = 32;
    localparam int PCT_W      = 7;
    localparam int QUO_W      = 7;
    localparam int PROD_W     = TRAVEL_W + QUO_W;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int ROUND_STEP = 5;
    localparam int PCT_FULL   = 100;

    localparam logic [TRAVEL_W-1:0] FULL_TRAVEL_RESET = TRAVEL_W'(7200);

    localparam logic ACT_CMD = 1'b0;
    localparam logic ACT_UPD = 1'b1;

    typedef enum logic [1:0] {
        MS_STOP  = 2'd0,
        MS_UP    = 2'd1,
        MS_DOWN  = 2'd2,
        MS_STOP2 = 2'd3
    } t_motion;

    typedef logic [PCT_W-1:0] t_pct_tab [2**PCT_W];

    function automatic t_motion next_motion(t_motion cur, logic up, logic down);
        t_motion s;
        s = cur;
        case (cur)
            MS_STOP: begin
                if (up) s = MS_UP;
                if (down) s = MS_DOWN;
            end
            MS_UP: begin
                if (!up) s = MS_STOP;
            end
            MS_DOWN: begin
                if (!down) s = MS_STOP;
            end
            default: begin
                if (!up && !down) s = MS_STOP;
            end
        endcase
        return s;
    endfunction

    // Rounds every possible quotient to the nearest step, saturating at full open.
    function automatic t_pct_tab build_round_tab();
        t_pct_tab tab;
        int r;
        int v;
        r = 0;
        for (int i = 0; i < 2**PCT_W; i++) begin
            if (r > ROUND_STEP / 2) v = i + ROUND_STEP - r;
            else v = i - r;
            if (v > PCT_FULL) v = PCT_FULL;
            tab[i] = PCT_W'(v);
            r = r + 1;
            if (r == ROUND_STEP) r = 0;
        end
        return tab;
    endfunction

    localparam t_pct_tab ROUND_TAB = build_round_tab();

endpackage

`default_nettype wire

// ===== design/smpt_div.sv =====
`default_nettype none

module smpt_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [smpt_pkg::PROD_W-1:0]  i_dividend,
    input  wire logic [smpt_pkg::TRAVEL_W-1:0] i_divisor,
    output logic                              o_done,
    output logic [smpt_pkg::QUO_W-1:0]        o_quotient
);
    import smpt_pkg::*;

    logic [PROD_W-1:0] r_rem;
    logic [PROD_W-1:0] r_dsh;
    logic [QUO_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              n_ge;
    logic [PROD_W-1:0] n_rem;

    always_comb begin
        n_ge  = (r_rem >= r_dsh);
        n_rem = n_ge ? (r_rem - r_dsh) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_dividend;
                r_dsh  <= PROD_W'(i_divisor) << (QUO_W - 1);
                r_quo  <= '0;
                r_cnt  <= CNT_W'(QUO_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dsh <= r_dsh >> 1;
                r_quo <= {r_quo[QUO_W-2:0], n_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== design/shutter_motion_position_tracker.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_valid / o_ready          i_action, i_up_request, i_down_request, i_now_ms
// result    out        o_valid / i_ready          o_motion, o_travel_ms, o_open_percent,
//                                                 o_motor_update
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (full travel time in ms)
//
// A command word, or an update word that does not move the position, goes from idle to execute
// to output. An update word that moves the position also passes the accumulate and multiply
// states, then waits in divide for the compare and subtract divider that forms the percentage.
// One word is in work at a time; the output register lets the next word in while a
// result waits, and that word then holds in its last cycle until the result is taken.
// Reset is synchronous and active low; the shutter then reads as closed.

module shutter_motion_position_tracker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_action,
    input  wire logic                          i_up_request,
    input  wire logic                          i_down_request,
    input  wire logic [smpt_pkg::TIME_W-1:0]   i_now_ms,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [1:0]                         o_motion,
    output logic [smpt_pkg::TRAVEL_W-1:0]      o_travel_ms,
    output logic [smpt_pkg::PCT_W-1:0]         o_open_percent,
    output logic                               o_motor_update,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [smpt_pkg::TRAVEL_W-1:0] i_cfg_data
);
    import smpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ACC,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state;
    logic                r_action;
    logic                r_up;
    logic                r_down;
    logic [TIME_W-1:0]   r_now;
    t_motion             r_motion;
    t_motion             r_before;
    t_motion             r_prev;
    logic                r_moving;
    logic [TIME_W-1:0]   r_last;
    logic [TIME_W-1:0]   r_elapsed;
    logic                r_upward;
    logic [TRAVEL_W-1:0] r_travel;
    logic [PCT_W-1:0]    r_pct;
    logic [TRAVEL_W-1:0] r_full;

    logic                r_out_valid;
    logic [1:0]          r_out_motion;
    logic [TRAVEL_W-1:0] r_out_travel;
    logic [PCT_W-1:0]    r_out_pct;
    logic                r_out_update;

    logic [TIME_W:0]     n_sum;
    logic [TRAVEL_W-1:0] n_down;
    logic [TRAVEL_W-1:0] n_travel;
    logic [PROD_W-1:0]   n_prod;
    logic [PCT_W-1:0]    n_pct;
    logic                n_div_start;
    logic                w_div_done;
    logic [QUO_W-1:0]    w_div_quo;

    // Saturating travel update from the elapsed time.
    always_comb begin
        n_sum = {1'b0, r_elapsed} + (TIME_W + 1)'(r_travel);
        if (r_elapsed >= TIME_W'(r_travel)) n_down = '0;
        else n_down = r_travel - r_elapsed[TRAVEL_W-1:0];
        if (r_upward) begin
            n_travel = (n_sum > (TIME_W + 1)'(r_full)) ? r_full : n_sum[TRAVEL_W-1:0];
        end else begin
            n_travel = (n_down > r_full) ? r_full : n_down;
        end
    end

    // The travel never exceeds the full travel here, so the quotient stays within 100.
    always_comb begin
        n_prod = (PROD_W'(r_travel) << 6) + (PROD_W'(r_travel) << 5)
               + (PROD_W'(r_travel) << 2);
        n_pct  = (r_full == '0) ? '0 : ROUND_TAB[w_div_quo];
        n_div_start = (r_state == S_MUL);
    end

    smpt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_prod),
        .i_divisor  (r_full),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_motion    <= MS_STOP;
            r_prev      <= MS_STOP;
            r_moving    <= 1'b0;
            r_last      <= '0;
            r_travel    <= '0;
            r_pct       <= '0;
            r_full      <= FULL_TRAVEL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_full <= i_cfg_data;
            if (r_out_valid && i_ready && r_state != S_OUT) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_action <= i_action;
                        r_up     <= i_up_request;
                        r_down   <= i_down_request;
                        r_now    <= i_now_ms;
                        r_before <= r_motion;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    if (r_action == ACT_CMD) begin
                        r_motion <= next_motion(r_motion, r_up, r_down);
                    end else begin
                        r_prev <= r_motion;
                        if (r_motion inside {MS_UP, MS_DOWN}) begin
                            r_last <= r_now;
                            if (r_moving) begin
                                r_elapsed <= r_now - r_last;
                                r_upward  <= (r_motion == MS_UP);
                                r_state   <= S_ACC;
                            end else begin
                                r_moving <= 1'b1;
                            end
                        end else begin
                            r_moving <= 1'b0;
                            if (r_prev inside {MS_UP, MS_DOWN}) begin
                                r_elapsed <= r_now - r_last;
                                r_upward  <= (r_prev == MS_UP);
                                r_state   <= S_ACC;
                            end
                        end
                    end
                end
                S_ACC: begin
                    r_travel <= n_travel;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_pct <= n_pct;
                        if (n_pct == '0 || n_pct == PCT_W'(PCT_FULL)) begin
                            r_motion <= next_motion(r_motion, 1'b0, 1'b0);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_motion <= r_motion;
                        r_out_travel <= r_travel;
                        r_out_pct    <= r_pct;
                        r_out_update <= (r_motion != r_before);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_motion       = r_out_motion;
    assign o_travel_ms    = r_out_travel;
    assign o_open_percent = r_out_pct;
    assign o_motor_update = r_out_update;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import smpt_pkg::*;

    localparam int CLK_HALF_NS     = 4;
    localparam int RESET_CYCLES    = 9;
    localparam int DRAIN_CYCLES    = 32;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        t_motion             motion;
        logic [TRAVEL_W-1:0] travel;
        logic [PCT_W-1:0]    pct;
        logic                motor_update;
    } t_shutter_view;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_action;
    logic                i_up_request;
    logic                i_down_request;
    logic [TIME_W-1:0]   i_now_ms;
    logic                o_valid;
    logic                i_ready;
    logic [1:0]          o_motion;
    logic [TRAVEL_W-1:0] o_travel_ms;
    logic [PCT_W-1:0]    o_open_percent;
    logic                o_motor_update;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [TRAVEL_W-1:0] i_cfg_data;

    // Shadow copy of the tracker state, advanced once per accepted word.
    t_motion             pred_motion;
    t_motion             pred_prev_motion;
    logic                pred_moving;
    logic [TIME_W-1:0]   pred_last_ms;
    logic [TRAVEL_W-1:0] pred_travel;
    logic [PCT_W-1:0]    pred_pct;
    logic [TRAVEL_W-1:0] pred_full;

    t_shutter_view       shutter_expect_q[$];
    t_shutter_view       oldest_view;

    logic [TIME_W-1:0]   clock_ms;
    logic                src_gaps_on;
    logic                sink_gaps_on;
    int                  sink_hold_cycles;
    int                  fail_count;
    int                  words_sent;
    int                  results_seen;
    int                  settings_done;
    int                  cycle_count;

    shutter_motion_position_tracker i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_up_request   (i_up_request),
        .i_down_request (i_down_request),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_motion       (o_motion),
        .o_travel_ms    (o_travel_ms),
        .o_open_percent (o_open_percent),
        .o_motor_update (o_motor_update),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF_NS i_clk = ~i_clk;

    function automatic t_motion advance_motion(t_motion cur, logic up, logic down);
        t_motion nxt;
        nxt = cur;
        case (cur)
            MS_STOP: begin
                if (down) nxt = MS_DOWN;
                else if (up) nxt = MS_UP;
            end
            MS_UP: begin
                if (!up) nxt = MS_STOP;
            end
            MS_DOWN: begin
                if (!down) nxt = MS_STOP;
            end
            default: begin
                if (!up && !down) nxt = MS_STOP;
            end
        endcase
        return nxt;
    endfunction

    function automatic logic [PCT_W-1:0] snap_percent(logic [31:0] p);
        logic [31:0] r;
        logic [31:0] v;
        r = p % ROUND_STEP;
        if (r > ROUND_STEP / 2) v = p + ROUND_STEP - r;
        else v = p - r;
        if (v > PCT_FULL) v = PCT_FULL;
        return v[PCT_W-1:0];
    endfunction

    task automatic accrue_travel(input logic [TIME_W-1:0] now, input logic upward);
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W:0]   sum;
        logic [31:0]       t;
        elapsed = now - pred_last_ms;
        t = {16'd0, pred_travel};
        if (upward) begin
            sum = {1'b0, t} + {1'b0, elapsed};
            t = (sum > {17'd0, pred_full}) ? {16'd0, pred_full} : sum[31:0];
        end else begin
            t = (elapsed >= t) ? 32'd0 : t - elapsed;
            if (t > {16'd0, pred_full}) t = {16'd0, pred_full};
        end
        pred_travel = t[TRAVEL_W-1:0];
        if (pred_full == 0) pred_pct = '0;
        else pred_pct = snap_percent((32'(pred_travel) * 32'd100) / 32'(pred_full));
        if (pred_pct == PCT_W'(PCT_FULL) || pred_pct == '0)
            pred_motion = advance_motion(pred_motion, 1'b0, 1'b0);
    endtask

    task automatic predict_word(input logic action, input logic up, input logic down,
                                input logic [TIME_W-1:0] now);
        t_motion       start;
        t_shutter_view view;
        start = pred_motion;
        if (action == ACT_CMD) begin
            pred_motion = advance_motion(pred_motion, up, down);
        end else begin
            if (start == MS_UP || start == MS_DOWN) begin
                if (pred_moving) accrue_travel(now, start == MS_UP);
                else pred_moving = 1'b1;
                pred_last_ms = now;
            end else begin
                pred_moving = 1'b0;
                if (pred_prev_motion == MS_UP || pred_prev_motion == MS_DOWN)
                    accrue_travel(now, pred_prev_motion == MS_UP);
            end
            pred_prev_motion = start;
        end
        view.motion       = pred_motion;
        view.travel       = pred_travel;
        view.pct          = pred_pct;
        view.motor_update = (pred_motion != start);
        shutter_expect_q.push_back(view);
    endtask

    task automatic send_word(input logic action, input logic up, input logic down,
                             input logic [TIME_W-1:0] now);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 5) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid        <= 1'b1;
        i_action       <= action;
        i_up_request   <= up;
        i_down_request <= down;
        i_now_ms       <= now;
        do @(posedge i_clk); while (!o_ready);
        predict_word(action, up, down, now);
        words_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (shutter_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_full_travel(input logic [TRAVEL_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        pred_full = value;
        settings_done++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly complete travel runs (request, timed updates, release) with stray words mixed in.
    task automatic run_shutter_traffic(input int n_words);
        int          sent;
        int          n_updates;
        int          pick;
        logic        go_up;
        logic        both;
        logic [31:0] step;
        sent = 0;
        clock_ms = $urandom;
        while (sent < n_words) begin
            src_gaps_on  = ($urandom_range(0, 3) != 0);
            sink_gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) < 15) begin
                send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom);
                sent++;
            end else begin
                go_up = 1'($urandom_range(0, 1));
                both  = ($urandom_range(0, 7) == 0);
                send_word(ACT_CMD, go_up | both, ~go_up | both, clock_ms);
                n_updates = $urandom_range(1, 8);
                repeat (n_updates) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0) step = 0;
                    else if (pick == 1) step = $urandom;
                    else step = $urandom_range(0, pred_full / 3 + 1);
                    clock_ms = clock_ms + step;
                    if ($urandom_range(0, 5) == 0)
                        send_word(ACT_CMD, go_up | both, ~go_up | both, clock_ms);
                    send_word(ACT_UPD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              clock_ms);
                    sent += 1;
                end
                clock_ms = clock_ms + $urandom_range(0, pred_full / 4 + 1);
                send_word(ACT_CMD, 1'b0, 1'b0, clock_ms);
                send_word(ACT_UPD, 1'b0, 1'b0, clock_ms);
                sent += 3;
            end
        end
    endtask

    task automatic test_directed_motion();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        send_word(ACT_UPD, 1'b0, 1'b0, TIME_W'(0));
        send_word(ACT_CMD, 1'b1, 1'b1, TIME_W'(0));
        send_word(ACT_CMD, 1'b0, 1'b1, TIME_W'(0));
        send_word(ACT_UPD, 1'b0, 1'b0, TIME_W'(100));
        send_word(ACT_UPD, 1'b1, 1'b1, TIME_W'(200));
        send_word(ACT_UPD, 1'b0, 1'b0, TIME_W'(300));
        send_word(ACT_CMD, 1'b1, 1'b0, TIME_W'(0));
        send_word(ACT_CMD, 1'b1, 1'b1, TIME_W'(0));
        send_word(ACT_UPD, 1'b0, 1'b0, 32'hFFFF_FF00);
        send_word(ACT_UPD, 1'b0, 1'b0, 32'h0000_0100);
        send_word(ACT_UPD, 1'b0, 1'b0, 32'h0000_0100);
        send_word(ACT_CMD, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_word(ACT_UPD, 1'b1, 1'b0, 32'hFFFF_FFFF);
        send_word(ACT_UPD, 1'b0, 1'b1, TIME_W'(0));
        src_gaps_on = 1'b0;
        send_word(ACT_CMD, 1'b0, 1'b1, TIME_W'(0));
        send_word(ACT_UPD, 1'b0, 1'b0, TIME_W'(1000));
        send_word(ACT_UPD, 1'b0, 1'b0, TIME_W'(1100));
        send_word(ACT_CMD, 1'b0, 1'b1, TIME_W'(1100));
        send_word(ACT_UPD, 1'b0, 1'b0, TIME_W'(2000));
        send_word(ACT_UPD, 1'b0, 1'b0, TIME_W'(2036));
        send_word(ACT_CMD, 1'b1, 1'b1, TIME_W'(2036));
        send_word(ACT_CMD, 1'b0, 1'b0, TIME_W'(2036));
        send_word(ACT_UPD, 1'b0, 1'b0, TIME_W'(2100));
    endtask

    task automatic test_full_travel_sweep();
        write_full_travel(16'hFFFF);
        run_shutter_traffic(45);
        write_full_travel(16'd1);
        run_shutter_traffic(45);
        write_full_travel(TRAVEL_W'($urandom_range(2, 300)));
        run_shutter_traffic(45);
        write_full_travel(FULL_TRAVEL_RESET);
        run_shutter_traffic(45);
        write_full_travel(TRAVEL_W'($urandom_range(1, 65535)));
        run_shutter_traffic(45);
    endtask

    // Travel built up against a long full travel stays above a shorter one until accounted.
    task automatic test_lowered_full_travel();
        write_full_travel(16'hFFFF);
        src_gaps_on = 1'b1;
        send_word(ACT_CMD, 1'b0, 1'b0, TIME_W'(0));
        send_word(ACT_CMD, 1'b1, 1'b0, TIME_W'(0));
        send_word(ACT_UPD, 1'b0, 1'b0, TIME_W'(5000));
        send_word(ACT_UPD, 1'b0, 1'b0, TIME_W'(65000));
        write_full_travel(TRAVEL_W'(1000));
        send_word(ACT_CMD, 1'b1, 1'b0, TIME_W'(65000));
        send_word(ACT_CMD, 1'b0, 1'b0, TIME_W'(65000));
        send_word(ACT_UPD, 1'b0, 1'b0, TIME_W'(65010));
        run_shutter_traffic(30);
    endtask

    task automatic test_result_backpressure();
        logic [TIME_W-1:0] t;
        drain_results();
        src_gaps_on      = 1'b0;
        sink_gaps_on     = 1'b1;
        sink_hold_cycles = HOLD_OFF_CYCLES;
        t = $urandom;
        send_word(ACT_CMD, 1'b0, 1'b0, t);
        send_word(ACT_CMD, 1'b1, 1'b0, t);
        repeat (22) begin
            t = t + $urandom_range(0, pred_full / 8 + 1);
            send_word(ACT_UPD, 1'b0, 1'b0, t);
        end
    endtask

    task automatic test_random_mix();
        write_full_travel(TRAVEL_W'($urandom_range(1, 65535)));
        run_shutter_traffic(45);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = ACT_CMD;
        i_up_request   = 1'b0;
        i_down_request = 1'b0;
        i_now_ms       = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        src_gaps_on    = 1'b1;
        sink_gaps_on   = 1'b1;
        clock_ms       = '0;
        pred_motion      = MS_STOP;
        pred_prev_motion = MS_STOP;
        pred_moving      = 1'b0;
        pred_last_ms     = '0;
        pred_travel      = '0;
        pred_pct         = '0;
        pred_full        = FULL_TRAVEL_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_motion();
        test_full_travel_sweep();
        test_lowered_full_travel();
        test_result_backpressure();
        test_random_mix();
        drain_results();

        $display("Run covered %0d words and %0d results over %0d full travel settings,",
                 words_sent, results_seen, settings_done);
        $display("with random idling on both sides and one long result hold-off.");
        if (fail_count == 0 && shutter_expect_q.size() == 0) begin
            $display("shutter_motion_position_tracker verification clean");
        end else begin
            $display("shutter_motion_position_tracker verification failed");
        end
        $finish;
    end

    // Result side: random stalls per word, plus one long hold-off when requested.
    initial begin
        int stall;
        i_ready          = 1'b0;
        sink_hold_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            if (sink_hold_cycles > 0) begin
                repeat (sink_hold_cycles) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
                sink_hold_cycles = 0;
            end
            stall = sink_gaps_on ? $urandom_range(0, 5) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                i_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        fail_count   = 0;
        words_sent   = 0;
        results_seen = 0;
        settings_done = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (shutter_expect_q.size() == 0) begin
                $error("result with no word outstanding: motion %0d travel %0d percent %0d",
                       o_motion, o_travel_ms, o_open_percent);
                fail_count++;
            end else begin
                oldest_view = shutter_expect_q.pop_front();
                if (o_motion !== oldest_view.motion) begin
                    $error("motion: expected %0d, got %0d", oldest_view.motion, o_motion);
                    fail_count++;
                end
                if (o_travel_ms !== oldest_view.travel) begin
                    $error("travel_ms: expected %0d, got %0d", oldest_view.travel, o_travel_ms);
                    fail_count++;
                end
                if (o_open_percent !== oldest_view.pct) begin
                    $error("open_percent: expected %0d, got %0d", oldest_view.pct,
                           o_open_percent);
                    fail_count++;
                end
                if (o_motor_update !== oldest_view.motor_update) begin
                    $error("motor_update: expected %0d, got %0d", oldest_view.motor_update,
                           o_motor_update);
                    fail_count++;
                end
            end
        end
    end

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("shutter_motion_position_tracker verification failed");
            $finish;
        end
    end

endmodule
